// File: hw/rtl/crb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the clipped rectangle blit address generator.
// No dependencies; imported by every other file of the block.
package crb_pkg;

  // Signed working width for clip arithmetic; wide enough for every
  // intermediate of a 14-bit corner shifted by a 14-bit offset.
  localparam int CoordW = 18;
  typedef logic signed [CoordW-1:0] coord_t;

  localparam int InW    = 14;   // input coordinate fields
  localparam int DimW   = 13;   // surface and clipped dimensions
  localparam int PitchW = 16;
  localparam int AddrW  = 32;
  localparam int BytesW = 15;
  localparam int ProdW  = DimW + PitchW;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 32;

  // 32-bit pixels: byte offsets are pixel counts shifted left by two.
  localparam int BppShift = 2;

  // Input action codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;
  localparam logic [1:0] ST_IDLE  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SRC_BASE   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_SRC_PITCH  = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_DST_BASE   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_DST_WIDTH  = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_DST_HEIGHT = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_DST_PITCH  = 4'd7;

  // Rectangle under clipping. "own" is the corner on the surface being
  // clipped against, "oth" the matching corner on the other surface.
  typedef struct packed {
    coord_t own_x;
    coord_t own_y;
    coord_t oth_x;
    coord_t oth_y;
    coord_t w;
    coord_t h;
  } geom_t;

endpackage

// File: hw/rtl/crb_clip.sv
`timescale 1ns / 1ps
// One clip pass of a rectangle against a surface: left, top, right, bottom.
// Depends on crb_pkg.
module crb_clip (
  input  crb_pkg::geom_t geom_in,
  input  crb_pkg::coord_t lim_w,
  input  crb_pkg::coord_t lim_h,
  output crb_pkg::geom_t geom_out
);
  import crb_pkg::*;

  coord_t x1, y1, ox1, oy1, w1, h1;

  always_comb begin
    // left and top edges: shift both corners, shrink the size
    if (geom_in.own_x[CoordW-1]) begin
      x1  = '0;
      ox1 = geom_in.oth_x - geom_in.own_x;
      w1  = geom_in.w + geom_in.own_x;
    end else begin
      x1  = geom_in.own_x;
      ox1 = geom_in.oth_x;
      w1  = geom_in.w;
    end
    if (geom_in.own_y[CoordW-1]) begin
      y1  = '0;
      oy1 = geom_in.oth_y - geom_in.own_y;
      h1  = geom_in.h + geom_in.own_y;
    end else begin
      y1  = geom_in.own_y;
      oy1 = geom_in.oth_y;
      h1  = geom_in.h;
    end

    geom_out.own_x = x1;
    geom_out.own_y = y1;
    geom_out.oth_x = ox1;
    geom_out.oth_y = oy1;
    // right and bottom edges
    geom_out.w = (x1 + w1 > lim_w) ? lim_w - x1 : w1;
    geom_out.h = (y1 + h1 > lim_h) ? lim_h - y1 : h1;
  end

endmodule

// File: hw/rtl/clipped_rect_blit_address_gen_unit.sv
`timescale 1ns / 1ps
// Clipped rectangle blit address generator, top level.
// Depends on crb_pkg and crb_clip.
//
// Usage:
//   Program the eight surface registers through the cfg_ port (always
//   ready; index 0..7, other indexes are dropped) while the block is idle.
//   Send a start beat (action 0) with a destination corner and a source
//   rectangle. The block clips it against the source surface, then against
//   the destination surface, and returns one beat: status 0 with the
//   clipped width and height, or status 1 when nothing is left. Each later
//   next beat (action 1) returns one row descriptor (status 2: source and
//   destination byte addresses, byte count, last-row flag). A next beat
//   with no active blit returns status 3. A start beat drops any active blit.
//
// Timing: five register stages (input, source clip, destination clip,
//   pitch multiply, result). One beat per cycle is sustained in both
//   directions while out_stall is low. Blit state (row counter, running
//   addresses) lives only in the result stage, so a next beat right behind
//   its start beat sees the new blit.
// Reset: synchronous, clears all stage valids, blit state, cfg registers.
// Stall: out_stall holds the result register; each stage fills its bubble
//   and in_stall rises once all stages hold a beat.
module clipped_rect_blit_address_gen_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [crb_pkg::CfgDataW-1:0]  cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic signed [crb_pkg::InW-1:0] in_dest_x,
  input  logic signed [crb_pkg::InW-1:0] in_dest_y,
  input  logic signed [crb_pkg::InW-1:0] in_rect_x,
  input  logic signed [crb_pkg::InW-1:0] in_rect_y,
  input  logic signed [crb_pkg::InW-1:0] in_rect_w,
  input  logic signed [crb_pkg::InW-1:0] in_rect_h,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [crb_pkg::AddrW-1:0]     out_src_addr,
  output logic [crb_pkg::AddrW-1:0]     out_dst_addr,
  output logic [crb_pkg::BytesW-1:0]    out_byte_count,
  output logic [crb_pkg::DimW-1:0]      out_clip_width,
  output logic [crb_pkg::DimW-1:0]      out_clip_height,
  output logic                          out_last_row
);
  import crb_pkg::*;

  localparam logic [DimW:0] MaxDimL = (DimW+1)'(MAX_DIM);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [AddrW-1:0]  src_base_r, dst_base_r;
  logic [DimW-1:0]   src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [PitchW-1:0] src_pitch_r, dst_pitch_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r   <= '0;
      src_width_r  <= '0;
      src_height_r <= '0;
      src_pitch_r  <= '0;
      dst_base_r   <= '0;
      dst_width_r  <= '0;
      dst_height_r <= '0;
      dst_pitch_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_BASE:   src_base_r   <= cfg_data;
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[DimW-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[DimW-1:0];
        REG_SRC_PITCH:  src_pitch_r  <= cfg_data[PitchW-1:0];
        REG_DST_BASE:   dst_base_r   <= cfg_data;
        REG_DST_WIDTH:  dst_width_r  <= cfg_data[DimW-1:0];
        REG_DST_HEIGHT: dst_height_r <= cfg_data[DimW-1:0];
        REG_DST_PITCH:  dst_pitch_r  <= cfg_data[PitchW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Surface limits, with oversized dimensions pinned to MAX_DIM.
  logic [DimW:0] lim_sw, lim_sh, lim_dw, lim_dh;
  coord_t        lim_sw_c, lim_sh_c, lim_dw_c, lim_dh_c;

  always_comb begin
    lim_sw = ({1'b0, src_width_r}  > MaxDimL) ? MaxDimL : {1'b0, src_width_r};
    lim_sh = ({1'b0, src_height_r} > MaxDimL) ? MaxDimL : {1'b0, src_height_r};
    lim_dw = ({1'b0, dst_width_r}  > MaxDimL) ? MaxDimL : {1'b0, dst_width_r};
    lim_dh = ({1'b0, dst_height_r} > MaxDimL) ? MaxDimL : {1'b0, dst_height_r};
    lim_sw_c = coord_t'({{(CoordW-DimW-1){1'b0}}, lim_sw});
    lim_sh_c = coord_t'({{(CoordW-DimW-1){1'b0}}, lim_sh});
    lim_dw_c = coord_t'({{(CoordW-DimW-1){1'b0}}, lim_dw});
    lim_dh_c = coord_t'({{(CoordW-DimW-1){1'b0}}, lim_dh});
  end

  // ---------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its beat moves on.
  // ---------------------------------------------------------------
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, out_vld_r;
  logic en_a, en_b, en_c, en_d, en_out;

  assign en_out   = !out_vld_r || !out_stall;
  assign en_d     = !d_vld_r   || en_out;
  assign en_c     = !c_vld_r   || en_d;
  assign en_b     = !b_vld_r   || en_c;
  assign en_a     = !a_vld_r   || en_b;
  assign in_stall = !en_a;

  // ---------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------
  logic               a_act_r;
  logic [InW-1:0]     a_dx_r, a_dy_r, a_x_r, a_y_r, a_w_r, a_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en_a) begin
      a_vld_r <= in_valid;
    end
    if (en_a && in_valid) begin
      a_act_r <= in_action;
      a_dx_r  <= in_dest_x;
      a_dy_r  <= in_dest_y;
      a_x_r   <= in_rect_x;
      a_y_r   <= in_rect_y;
      a_w_r   <= in_rect_w;
      a_h_r   <= in_rect_h;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: clip against the source surface
  // ---------------------------------------------------------------
  geom_t src_in, src_out, dst_in, dst_out;
  geom_t b_geom_r, c_geom_r;
  logic  b_act_r, c_act_r;

  always_comb begin
    src_in.own_x = coord_t'({{(CoordW-InW){a_x_r[InW-1]}},  a_x_r});
    src_in.own_y = coord_t'({{(CoordW-InW){a_y_r[InW-1]}},  a_y_r});
    src_in.oth_x = coord_t'({{(CoordW-InW){a_dx_r[InW-1]}}, a_dx_r});
    src_in.oth_y = coord_t'({{(CoordW-InW){a_dy_r[InW-1]}}, a_dy_r});
    src_in.w     = coord_t'({{(CoordW-InW){a_w_r[InW-1]}},  a_w_r});
    src_in.h     = coord_t'({{(CoordW-InW){a_h_r[InW-1]}},  a_h_r});
  end

  crb_clip u_clip_src (
    .geom_in  (src_in),
    .lim_w    (lim_sw_c),
    .lim_h    (lim_sh_c),
    .geom_out (src_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en_b) begin
      b_vld_r <= a_vld_r;
    end
    if (en_b && a_vld_r) begin
      b_act_r  <= a_act_r;
      b_geom_r <= src_out;
    end
  end

  // ---------------------------------------------------------------
  // Stage C: clip against the destination surface (swap the corners)
  // ---------------------------------------------------------------
  always_comb begin
    dst_in.own_x = b_geom_r.oth_x;
    dst_in.own_y = b_geom_r.oth_y;
    dst_in.oth_x = b_geom_r.own_x;
    dst_in.oth_y = b_geom_r.own_y;
    dst_in.w     = b_geom_r.w;
    dst_in.h     = b_geom_r.h;
  end

  crb_clip u_clip_dst (
    .geom_in  (dst_in),
    .lim_w    (lim_dw_c),
    .lim_h    (lim_dh_c),
    .geom_out (dst_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en_c) begin
      c_vld_r <= b_vld_r;
    end
    if (en_c && b_vld_r) begin
      c_act_r  <= b_act_r;
      c_geom_r <= dst_out;   // own = destination, oth = source
    end
  end

  // ---------------------------------------------------------------
  // Stage D: row offsets (row times pitch), emptiness test
  // ---------------------------------------------------------------
  logic              d_act_r, d_empty_r;
  logic [ProdW-1:0]  d_src_prod_r, d_dst_prod_r;
  logic [DimW-1:0]   d_src_x_r, d_dst_x_r, d_w_r, d_h_r;
  logic              c_empty;

  assign c_empty = c_geom_r.w[CoordW-1] || (c_geom_r.w == '0) ||
                   c_geom_r.h[CoordW-1] || (c_geom_r.h == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en_d) begin
      d_vld_r <= c_vld_r;
    end
    if (en_d && c_vld_r) begin
      d_act_r      <= c_act_r;
      d_empty_r    <= c_empty;
      // corners are within [0, MAX_DIM) whenever the rectangle is not empty
      d_src_prod_r <= c_geom_r.oth_y[DimW-1:0] * src_pitch_r;
      d_dst_prod_r <= c_geom_r.own_y[DimW-1:0] * dst_pitch_r;
      d_src_x_r    <= c_geom_r.oth_x[DimW-1:0];
      d_dst_x_r    <= c_geom_r.own_x[DimW-1:0];
      d_w_r        <= c_geom_r.w[DimW-1:0];
      d_h_r        <= c_geom_r.h[DimW-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Result stage: blit state and result register
  // ---------------------------------------------------------------
  logic              busy_r, busy_nxt;
  logic [DimW-1:0]   rows_r, rows_nxt;
  logic [AddrW-1:0]  cur_src_r, cur_src_nxt, cur_dst_r, cur_dst_nxt;
  logic [BytesW-1:0] row_len_r, row_len_nxt;

  logic [1:0]        status_r, status_nxt;
  logic [AddrW-1:0]  src_addr_r, src_addr_nxt, dst_addr_r, dst_addr_nxt;
  logic [BytesW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [DimW-1:0]   clip_w_r, clip_w_nxt, clip_h_r, clip_h_nxt;
  logic              last_r, last_nxt;

  logic [AddrW-1:0]  start_src, start_dst;
  logic              take_d;

  assign take_d = en_out && d_vld_r;

  // first-row addresses: base + row offset + column bytes
  assign start_src = src_base_r + AddrW'(d_src_prod_r)
                   + AddrW'({d_src_x_r, {BppShift{1'b0}}});
  assign start_dst = dst_base_r + AddrW'(d_dst_prod_r)
                   + AddrW'({d_dst_x_r, {BppShift{1'b0}}});

  always_comb begin
    busy_nxt     = busy_r;
    rows_nxt     = rows_r;
    cur_src_nxt  = cur_src_r;
    cur_dst_nxt  = cur_dst_r;
    row_len_nxt  = row_len_r;
    status_nxt   = ST_IDLE;
    src_addr_nxt = '0;
    dst_addr_nxt = '0;
    byte_cnt_nxt = '0;
    clip_w_nxt   = '0;
    clip_h_nxt   = '0;
    last_nxt     = 1'b0;

    case (d_act_r)
      ACT_START: begin
        if (d_empty_r) begin
          busy_nxt   = 1'b0;
          rows_nxt   = '0;
          status_nxt = ST_EMPTY;
        end else begin
          busy_nxt    = 1'b1;
          rows_nxt    = d_h_r;
          cur_src_nxt = start_src;
          cur_dst_nxt = start_dst;
          row_len_nxt = BytesW'({d_w_r, {BppShift{1'b0}}});
          status_nxt  = ST_START;
          clip_w_nxt  = d_w_r;
          clip_h_nxt  = d_h_r;
        end
      end
      ACT_NEXT: begin
        if (!busy_r || rows_r == '0) begin
          busy_nxt   = 1'b0;
          status_nxt = ST_IDLE;
        end else begin
          status_nxt   = ST_ROW;
          src_addr_nxt = cur_src_r;
          dst_addr_nxt = cur_dst_r;
          byte_cnt_nxt = row_len_r;
          last_nxt     = (rows_r == DimW'(1));
          // advance to the next row
          cur_src_nxt  = cur_src_r + AddrW'(src_pitch_r);
          cur_dst_nxt  = cur_dst_r + AddrW'(dst_pitch_r);
          rows_nxt     = rows_r - DimW'(1);
          busy_nxt     = (rows_r != DimW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      busy_r    <= 1'b0;
      rows_r    <= '0;
      cur_src_r <= '0;
      cur_dst_r <= '0;
      row_len_r <= '0;
    end else begin
      if (en_out) begin
        out_vld_r <= d_vld_r;
      end
      if (take_d) begin
        busy_r    <= busy_nxt;
        rows_r    <= rows_nxt;
        cur_src_r <= cur_src_nxt;
        cur_dst_r <= cur_dst_nxt;
        row_len_r <= row_len_nxt;
      end
    end
    if (take_d) begin
      status_r   <= status_nxt;
      src_addr_r <= src_addr_nxt;
      dst_addr_r <= dst_addr_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      clip_w_r   <= clip_w_nxt;
      clip_h_r   <= clip_h_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = status_r;
  assign out_src_addr    = src_addr_r;
  assign out_dst_addr    = dst_addr_r;
  assign out_byte_count  = byte_cnt_r;
  assign out_clip_width  = clip_w_r;
  assign out_clip_height = clip_h_r;
  assign out_last_row    = last_r;

endmodule

// File: hw/rtl/crb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the clipped rectangle blit address generator,
// bound to the top level. Depends on crb_pkg.
module crb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_status,
  input logic [crb_pkg::AddrW-1:0]    out_src_addr,
  input logic [crb_pkg::BytesW-1:0]   out_byte_count,
  input logic [crb_pkg::DimW-1:0]     out_clip_width,
  input logic [crb_pkg::DimW-1:0]     out_clip_height,
  input logic                         out_last_row
);
  import crb_pkg::*;

  // result valid is low the cycle after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_src_addr) && $stable(out_byte_count))
    else $error("stalled result changed");

  // last-row flag and row fields only on row descriptors
  a_row_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ROW |->
      !out_last_row && out_byte_count == '0 && out_src_addr == '0)
    else $error("row fields set outside a row descriptor");

  // clipped size is reported only by a nonempty start, and then nonzero
  a_clip_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_START) ==
      (out_clip_width != '0 && out_clip_height != '0))
    else $error("clip size inconsistent with status");

endmodule

bind clipped_rect_blit_address_gen_unit crb_checker u_crb_checker (.*);
